>>> rtl/core/bus_token_scheduler_top_defines.svh
// Assertion macros for the token scheduler.
`ifndef BUS_TOKEN_SCHEDULER_TOP_DEFINES_SVH
`define BUS_TOKEN_SCHEDULER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define BTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BTS_ASSERT(lbl, prop, msg)
`define BTS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/core/bts_pkg.sv
package bts_pkg;

  localparam int NODE_W    = 7;
  localparam int BYTE_W    = 8;
  localparam int ROW_AW    = 4;
  localparam int ROW_W     = 1 << ROW_AW;
  localparam int ROW_SEL_W = NODE_W - ROW_AW;
  localparam int MAP_ROWS  = 1 << ROW_SEL_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 8;

  localparam int unsigned BTS_FIRST_NODE = 1;
  localparam int unsigned BTS_LAST_NODE  = 127;

  localparam logic [NODE_W-1:0] OWN_ADDRESS_RST = 7'd1;
  localparam logic [7:0]        MAX_FAILS_RST   = 8'd3;
  localparam logic [7:0]        SLEEP_LAPS_RST  = 8'd10;

  localparam logic TOKEN_MARK = 1'b1;

  typedef struct packed {
    logic                 rd_en;
    logic [ROW_SEL_W-1:0] rd_row;
    logic                 wr_en;
    logic [ROW_SEL_W-1:0] wr_row;
    logic [ROW_W-1:0]     wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [NODE_W-1:0] token_node;
    logic              probing;
    logic              node_dropped;
    logic              sleep_request;
  } res_t;

endpackage

>>> rtl/core/bus_token_scheduler_top.sv
// channel   direction  handshake              payload
// in        input      in_valid / in_stall    op, has_payload, node_address, online
// out       output     out_valid / out_stall  token_node, token_byte, probing, is_own,
//                                             node_dropped, sleep_request
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item at a time; in_stall is high from the accepting edge until the result is loaded.
// Grant: up to three scans of the 8 x 16 bit presence memory, one row per cycle, plus a
// read-modify-write of one row when the own node's bit is written. Other ops go straight
// to the result, or when they write the presence memory do a read-modify-write of one row.
// rst clears the row valid bits at once, so the whole map reads absent; no clearing pass.
// out_stall holds the result register; a new item is taken while it waits.
`include "bus_token_scheduler_top_defines.svh"

module bus_token_scheduler_top import bts_pkg::*; #(
  parameter int unsigned FIRST_NODE = BTS_FIRST_NODE,
  parameter int unsigned LAST_NODE  = BTS_LAST_NODE
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           op,
  input  logic                 has_payload,
  input  logic [NODE_W-1:0]    node_address,
  input  logic                 online,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [NODE_W-1:0]    token_node,
  output logic [BYTE_W-1:0]    token_byte,
  output logic                 probing,
  output logic                 is_own,
  output logic                 node_dropped,
  output logic                 sleep_request,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FAILS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_LAPS  = 2'd2;

  logic [NODE_W-1:0] own_address;
  logic [7:0]        max_fails;
  logic [7:0]        sleep_laps;
  logic              busy;
  logic              res_ready;
  logic              res_load;
  res_t              res;
  mem_req_t          mem_req;
  logic [ROW_W-1:0]  row_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= OWN_ADDRESS_RST;
      max_fails   <= MAX_FAILS_RST;
      sleep_laps  <= SLEEP_LAPS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OWN_ADDRESS: own_address <= cfg_data[NODE_W-1:0];
        REG_MAX_FAILS:   max_fails   <= cfg_data;
        REG_SLEEP_LAPS:  sleep_laps  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bts_map_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rd_data (row_data)
  );

  bts_ctrl #(
    .FIRST_NODE (FIRST_NODE),
    .LAST_NODE  (LAST_NODE)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (in_valid && !in_stall),
    .op           (op),
    .has_payload  (has_payload),
    .node_address (node_address),
    .online       (online),
    .own_address  (own_address),
    .max_fails    (max_fails),
    .sleep_laps   (sleep_laps),
    .row_data     (row_data),
    .res_ready    (res_ready),
    .busy         (busy),
    .mem_req      (mem_req),
    .res          (res),
    .res_load     (res_load)
  );

  assign in_stall  = busy;
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      token_node    <= res.token_node;
      probing       <= res.probing;
      is_own        <= res.token_node == own_address;
      node_dropped  <= res.node_dropped;
      sleep_request <= res.sleep_request;
    end
  end

  assign token_byte = {TOKEN_MARK, token_node};

  `BTS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted item not held busy")
  `BTS_ASSERT(a_load_into_free, !res_load || !out_valid || !out_stall, "result overwrote a waiting result")
  `BTS_ASSERT(a_mem_one_access, !(mem_req.rd_en && mem_req.wr_en), "map read and write in one cycle")

endmodule

>>> rtl/core/bts_map_mem.sv
module bts_map_mem import bts_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  mem_req_t         req,
  output logic [ROW_W-1:0] rd_data
);

  logic [ROW_W-1:0]    mem [MAP_ROWS];
  logic [MAP_ROWS-1:0] row_valid;
  logic [ROW_W-1:0]    rd_raw;
  logic                rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_row] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_raw <= mem[req.rd_row];
    end
  end

  // rows never written read as all absent
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_valid[req.wr_row] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid <= row_valid[req.rd_row];
      end
    end
  end

  assign rd_data = rd_valid ? rd_raw : '0;

endmodule

>>> rtl/core/bts_row_find.sv
module bts_row_find import bts_pkg::*; (
  input  logic [ROW_W-1:0]     row_bits,
  input  logic                 want_present,
  input  logic [ROW_SEL_W-1:0] row,
  input  logic [NODE_W:0]      lo,
  input  logic [NODE_W:0]      hi,
  output logic                 hit,
  output logic [ROW_AW-1:0]    idx
);

  logic [ROW_W-1:0] cand;
  logic [NODE_W:0]  pos;

  always_comb begin
    pos = '0;
    for (int b = 0; b < ROW_W; b++) begin
      pos     = {1'b0, row, ROW_AW'(b)};
      cand[b] = (want_present ? row_bits[b] : ~row_bits[b]) && (pos >= lo) && (pos <= hi);
    end
  end

  // lowest candidate wins
  always_comb begin
    idx = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        idx = ROW_AW'(b);
      end
    end
  end

  assign hit = |cand;

endmodule

>>> rtl/core/bts_ctrl.sv
module bts_ctrl import bts_pkg::*; #(
  parameter int unsigned FIRST_NODE = BTS_FIRST_NODE,
  parameter int unsigned LAST_NODE  = BTS_LAST_NODE
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2:0]        op,
  input  logic              has_payload,
  input  logic [NODE_W-1:0] node_address,
  input  logic              online,
  input  logic [NODE_W-1:0] own_address,
  input  logic [7:0]        max_fails,
  input  logic [7:0]        sleep_laps,
  input  logic [ROW_W-1:0]  row_data,
  input  logic              res_ready,
  output logic              busy,
  output mem_req_t          mem_req,
  output res_t              res,
  output logic              res_load
);

  localparam logic [NODE_W:0]   FIRST_EXT = (NODE_W + 1)'(FIRST_NODE);
  localparam logic [NODE_W:0]   LAST_EXT  = (NODE_W + 1)'(LAST_NODE);
  localparam logic [NODE_W-1:0] FIRST_N   = NODE_W'(FIRST_NODE);

  typedef enum logic [2:0] {
    OP_GRANT        = 3'd0,
    OP_ANSWER       = 3'd1,
    OP_ANS_TIMEOUT  = 3'd2,
    OP_SEND_TIMEOUT = 3'd3,
    OP_SET_NODE     = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_LAUNCH, S_SCAN, S_GFIN, S_RMW_RD, S_RMW_WR, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_SERVE, PH_PROBE_A, PH_PROBE_B
  } phase_t;

  typedef struct packed {
    logic [NODE_W-1:0] tracked;
    logic [7:0]        miss;
    logic              drop;
  } miss_t;

  function automatic miss_t count_miss(input logic [NODE_W-1:0] n,
                                       input logic [NODE_W-1:0] trk,
                                       input logic [7:0]        cnt,
                                       input logic [7:0]        limit);
    miss_t      r;
    logic [7:0] inc;
    r.tracked = trk;
    r.miss    = cnt;
    r.drop    = 1'b0;
    inc       = cnt + 8'd1;
    if (trk == '0) begin
      r.tracked = n;
    end else if (n == trk) begin
      r.miss = inc;
      if (inc >= limit) begin
        r.tracked = '0;
        r.miss    = '0;
        r.drop    = 1'b1;
      end
    end
    return r;
  endfunction

  state_t               state;
  phase_t               phase;
  logic [NODE_W:0]      seg_lo;
  logic [NODE_W:0]      seg_hi;
  logic                 want_present;
  logic [ROW_SEL_W-1:0] row;
  logic                 lap;
  logic [NODE_W-1:0]    serve;
  logic [NODE_W-1:0]    probe;
  logic                 lwp;
  logic [NODE_W-1:0]    holder;
  logic [NODE_W-1:0]    tracked;
  logic [7:0]           miss;
  logic [7:0]           countdown;
  logic [NODE_W-1:0]    rmw_node;
  logic                 rmw_val;
  logic                 dropped;
  logic                 sleep_req;

  logic [NODE_W:0]      launch_lo;
  logic [NODE_W:0]      launch_hi;
  logic                 launch_want;
  logic                 launch_empty;
  logic                 find_hit;
  logic [ROW_AW-1:0]    find_idx;
  logic                 row_last;
  logic [NODE_W-1:0]    found;
  logic                 seg_hit;
  logic                 seg_fail;
  miss_t                miss_res;
  logic                 drop_now;
  logic                 sleep_now;

  bts_row_find u_find (
    .row_bits     (row_data),
    .want_present (want_present),
    .row          (row),
    .lo           (seg_lo),
    .hi           (seg_hi),
    .hit          (find_hit),
    .idx          (find_idx)
  );

  always_comb begin
    case (phase)
      PH_SERVE: begin
        launch_lo   = lwp ? {1'b0, serve} : {1'b0, serve} + (NODE_W + 1)'(1);
        launch_hi   = lwp ? {1'b0, serve} : LAST_EXT;
        launch_want = 1'b1;
      end
      PH_PROBE_A: begin
        launch_lo   = {1'b0, probe} + (NODE_W + 1)'(1);
        launch_hi   = LAST_EXT;
        launch_want = 1'b0;
      end
      PH_PROBE_B: begin
        launch_lo   = FIRST_EXT;
        launch_hi   = {1'b0, probe};
        launch_want = 1'b0;
      end
      default: begin
        launch_lo   = '1;
        launch_hi   = '0;
        launch_want = 1'b0;
      end
    endcase
  end

  assign launch_empty = launch_lo > launch_hi;
  assign row_last     = row == seg_hi[NODE_W-1:ROW_AW];
  assign found        = {row, find_idx};
  assign seg_hit      = (state == S_SCAN) && find_hit;
  assign seg_fail     = ((state == S_LAUNCH) && launch_empty) ||
                        ((state == S_SCAN) && !find_hit && row_last);
  assign miss_res     = count_miss(holder, tracked, miss, max_fails);
  assign drop_now     = miss_res.drop &&
                        ((op == OP_SEND_TIMEOUT) || ((op == OP_ANS_TIMEOUT) && !lwp));
  assign sleep_now    = (op == OP_ANS_TIMEOUT) && (countdown == '0);

  always_comb begin
    mem_req = '0;
    case (state)
      S_LAUNCH: begin
        mem_req.rd_en  = !launch_empty;
        mem_req.rd_row = launch_lo[NODE_W-1:ROW_AW];
      end
      S_SCAN: begin
        mem_req.rd_en  = !find_hit && !row_last;
        mem_req.rd_row = row + ROW_SEL_W'(1);
      end
      S_RMW_RD: begin
        mem_req.rd_en  = 1'b1;
        mem_req.rd_row = rmw_node[NODE_W-1:ROW_AW];
      end
      S_RMW_WR: begin
        mem_req.wr_en                           = 1'b1;
        mem_req.wr_row                          = rmw_node[NODE_W-1:ROW_AW];
        mem_req.wr_data                         = row_data;
        mem_req.wr_data[rmw_node[ROW_AW-1:0]]   = rmw_val;
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_SERVE;
      lap       <= 1'b0;
      serve     <= FIRST_N;
      probe     <= FIRST_N;
      lwp       <= 1'b1;
      holder    <= '0;
      tracked   <= '0;
      miss      <= '0;
      countdown <= SLEEP_LAPS_RST;
      dropped   <= 1'b0;
      sleep_req <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            dropped   <= drop_now;
            sleep_req <= sleep_now;
            case (op)
              OP_GRANT: begin
                phase <= PH_SERVE;
                lap   <= 1'b0;
                state <= S_LAUNCH;
              end
              OP_ANSWER: begin
                if (has_payload) begin
                  countdown <= sleep_laps;
                end
                if (lwp) begin
                  rmw_node <= holder;
                  rmw_val  <= 1'b1;
                  state    <= S_RMW_RD;
                end else begin
                  if (holder == tracked) begin
                    tracked <= '0;
                    miss    <= '0;
                  end
                  state <= S_DONE;
                end
              end
              OP_ANS_TIMEOUT: begin
                if (!lwp) begin
                  tracked <= miss_res.tracked;
                  miss    <= miss_res.miss;
                end
                if (sleep_now) begin
                  countdown <= sleep_laps;
                end
                if (drop_now) begin
                  rmw_node <= holder;
                  rmw_val  <= 1'b0;
                  state    <= S_RMW_RD;
                end else begin
                  state <= S_DONE;
                end
              end
              OP_SEND_TIMEOUT: begin
                tracked <= miss_res.tracked;
                miss    <= miss_res.miss;
                if (drop_now) begin
                  rmw_node <= holder;
                  rmw_val  <= 1'b0;
                  state    <= S_RMW_RD;
                end else begin
                  state <= S_DONE;
                end
              end
              OP_SET_NODE: begin
                rmw_node <= node_address;
                rmw_val  <= online;
                state    <= S_RMW_RD;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_LAUNCH: begin
          if (!launch_empty) begin
            seg_lo       <= launch_lo;
            seg_hi       <= launch_hi;
            want_present <= launch_want;
            row          <= launch_lo[NODE_W-1:ROW_AW];
            state        <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!find_hit && !row_last) begin
            row <= row + ROW_SEL_W'(1);
          end
        end
        S_GFIN: begin
          if (lap && countdown != '0) begin
            countdown <= countdown - 8'd1;
          end
          if (holder == own_address) begin
            rmw_node <= own_address;
            rmw_val  <= 1'b1;
            state    <= S_RMW_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_RMW_RD: begin
          state <= S_RMW_WR;
        end
        S_RMW_WR: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (seg_hit) begin
        holder <= found;
        state  <= S_GFIN;
        case (phase)
          PH_SERVE: begin
            serve <= found;
            lwp   <= 1'b0;
          end
          PH_PROBE_A: begin
            probe <= found;
            lwp   <= 1'b1;
          end
          default: begin
            probe <= found;
            lwp   <= 1'b1;
            lap   <= 1'b1;
          end
        endcase
      end

      if (seg_fail) begin
        case (phase)
          PH_SERVE: begin
            if (!lwp) begin
              serve <= FIRST_N;
            end
            phase <= PH_PROBE_A;
            state <= S_LAUNCH;
          end
          PH_PROBE_A: begin
            phase <= PH_PROBE_B;
            lap   <= 1'b1;
            state <= S_LAUNCH;
          end
          default: begin
            // every node present: serve slot takes the token
            lap    <= 1'b1;
            holder <= serve;
            lwp    <= 1'b0;
            state  <= S_GFIN;
          end
        endcase
      end
    end
  end

  assign busy     = state != S_IDLE;
  assign res_load = (state == S_DONE) && res_ready;
  assign res      = '{token_node: holder, probing: lwp, node_dropped: dropped,
                      sleep_request: sleep_req};

endmodule

>>> test/tb_bus_token_scheduler_top.sv
`timescale 1ns / 100ps

module tb_bus_token_scheduler_top;
  import bts_pkg::*;

  localparam logic [2:0] OP_GRANT        = 3'd0;
  localparam logic [2:0] OP_ANSWER       = 3'd1;
  localparam logic [2:0] OP_ANS_TIMEOUT  = 3'd2;
  localparam logic [2:0] OP_SEND_TIMEOUT = 3'd3;
  localparam logic [2:0] OP_SET_NODE     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FAILS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_LAPS  = 2'd2;

  localparam int PHASES     = 6;
  localparam int PHASE_OPS  = 225;
  localparam int MAX_PRINTS = 60;

  typedef struct packed {
    logic [2:0]        op;
    logic              has_payload;
    logic [NODE_W-1:0] node_address;
    logic              online;
  } bus_op_t;

  typedef struct packed {
    logic [NODE_W-1:0] token_node;
    logic [BYTE_W-1:0] token_byte;
    logic              probing;
    logic              is_own;
    logic              node_dropped;
    logic              sleep_request;
  } token_status_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [2:0]           op = '0;
  logic                 has_payload = 1'b0;
  logic [NODE_W-1:0]    node_address = '0;
  logic                 online = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [NODE_W-1:0]    token_node;
  logic [BYTE_W-1:0]    token_byte;
  logic                 probing;
  logic                 is_own;
  logic                 node_dropped;
  logic                 sleep_request;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  bus_token_scheduler_top dut (.*);

  // scheduler shadow state
  bit [127:0]        node_present = '0;
  int                serve_ptr = BTS_FIRST_NODE;
  int                probe_ptr = BTS_FIRST_NODE;
  bit                probe_active = 1'b1;
  logic [NODE_W-1:0] holder = '0;
  logic [NODE_W-1:0] claimed_node = '0;
  logic [7:0]        misses = '0;
  logic [7:0]        laps_left = SLEEP_LAPS_RST;
  logic [NODE_W-1:0] own_addr = OWN_ADDRESS_RST;
  logic [7:0]        fail_limit = MAX_FAILS_RST;
  logic [7:0]        laps_reload = SLEEP_LAPS_RST;

  bus_op_t       bus_ops[$];
  token_status_t predicted_status[$];
  bus_op_t       cur_op;
  token_status_t want;
  int            fail_count = 0;
  bit            quiet = 1'b0;
  int            in_gap = 0;
  int            in_calm = 0;
  int            out_gap = 0;
  int            out_calm = 0;

  function automatic logic [NODE_W-1:0] pick_next_token();
    int  found = 0;
    bit  second = 1'b0;
    bit  lap_done = 1'b0;
    int  start;
    for (int pass = 0; pass < 2 && found == 0; pass++) begin
      if (probe_active || second) begin
        if (node_present[serve_ptr]) begin
          found = serve_ptr;
          probe_active = 1'b0;
        end
      end else begin
        for (int i = 0; i < 130; i++) begin
          serve_ptr++;
          if (serve_ptr > BTS_LAST_NODE) begin
            serve_ptr = BTS_FIRST_NODE;
            break;
          end
          if (node_present[serve_ptr]) begin
            found = serve_ptr;
            probe_active = 1'b0;
            break;
          end
        end
      end
      if (found == 0) begin
        start = probe_ptr;
        for (int i = 0; i < 130; i++) begin
          probe_ptr++;
          if (probe_ptr > BTS_LAST_NODE) begin
            probe_ptr = BTS_FIRST_NODE;
            lap_done = 1'b1;
          end
          if (!node_present[probe_ptr]) begin
            found = probe_ptr;
            probe_active = 1'b1;
            break;
          end
          if (probe_ptr == start) break;
        end
      end
      second = 1'b1;
    end
    if (lap_done && laps_left != 0) laps_left--;
    return found[NODE_W-1:0];
  endfunction

  function automatic bit note_miss(logic [NODE_W-1:0] n);
    if (claimed_node == 0) begin
      claimed_node = n;
    end else if (n == claimed_node) begin
      misses++;
      if (misses >= fail_limit) begin
        node_present[n] = 1'b0;
        claimed_node = '0;
        misses = '0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic token_status_t schedule_op(bus_op_t it);
    token_status_t r;
    bit dropped = 1'b0;
    bit sleep_req = 1'b0;
    case (it.op)
      OP_GRANT: begin
        holder = pick_next_token();
        if (holder == own_addr) node_present[own_addr] = 1'b1;
      end
      OP_ANSWER: begin
        if (it.has_payload) laps_left = laps_reload;
        if (probe_active) begin
          node_present[holder] = 1'b1;
        end else if (holder == claimed_node) begin
          claimed_node = '0;
          misses = '0;
        end
      end
      OP_ANS_TIMEOUT: begin
        if (!probe_active) dropped = note_miss(holder);
        if (laps_left == 0) begin
          laps_left = laps_reload;
          sleep_req = 1'b1;
        end
      end
      OP_SEND_TIMEOUT: begin
        dropped = note_miss(holder);
      end
      OP_SET_NODE: begin
        node_present[it.node_address] = it.online;
      end
      default: begin
      end
    endcase
    r.token_node    = holder;
    r.token_byte    = {TOKEN_MARK, holder};
    r.probing       = probe_active;
    r.is_own        = (holder == own_addr);
    r.node_dropped  = dropped;
    r.sleep_request = sleep_req;
    return r;
  endfunction

  task automatic report(string msg);
    if (fail_count < MAX_PRINTS) $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, int got, int exp_val);
    if (got != exp_val) report($sformatf("%s got 0x%0h expected 0x%0h", name, got, exp_val));
  endtask

  task automatic add_op(logic [2:0] o, logic pay, logic [NODE_W-1:0] addr, logic onl);
    bus_op_t it;
    it.op = o;
    it.has_payload = pay;
    it.node_address = addr;
    it.online = onl;
    bus_ops.push_back(it);
  endtask

  task automatic add_traffic(int count);
    int added = 0;
    int r;
    int k;
    logic [2:0] resp;
    while (added < count) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        // bus cycle: grant followed by what the node did
        add_op(OP_GRANT, 1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
               1'($urandom_range(0, 1)));
        k = $urandom_range(0, 99);
        resp = (k < 55) ? OP_ANSWER : (k < 80) ? OP_ANS_TIMEOUT : OP_SEND_TIMEOUT;
        add_op(resp, 1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
               1'($urandom_range(0, 1)));
        added += 2;
      end else if (r < 85) begin
        add_op(OP_SET_NODE, 1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
               $urandom_range(0, 9) < 6);
        added++;
      end else if (r < 95) begin
        resp = 3'($urandom_range(OP_GRANT, OP_SEND_TIMEOUT));
        add_op(resp, 1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
               1'($urandom_range(0, 1)));
        added++;
      end else begin
        add_op(3'(OP_SET_NODE + $urandom_range(1, 3)), 1'($urandom_range(0, 1)),
               7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
        added++;
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_OWN_ADDRESS: own_addr = val[NODE_W-1:0];
      REG_MAX_FAILS:   fail_limit = val;
      REG_SLEEP_LAPS:  laps_reload = val;
      default: begin
      end
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (bus_ops.size() != 0 || in_valid || predicted_status.size() != 0);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // item driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predicted_status.push_back(schedule_op(cur_op));
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && in_calm == 0 && $urandom_range(0, 3) == 0) begin
          in_gap = $urandom_range(1, 8) - 1;
          if ($urandom_range(0, 2) == 0) in_calm = $urandom_range(10, 60);
          in_valid <= 1'b0;
        end else if (bus_ops.size() != 0) begin
          cur_op = bus_ops.pop_front();
          if (in_calm > 0) in_calm--;
          in_valid     <= 1'b1;
          op           <= cur_op.op;
          has_payload  <= cur_op.has_payload;
          node_address <= cur_op.node_address;
          online       <= cur_op.online;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_status.size() == 0) begin
          report("result with nothing expected");
        end else begin
          want = predicted_status.pop_front();
          check_field("token_node", int'(token_node), int'(want.token_node));
          check_field("token_byte", int'(token_byte), int'(want.token_byte));
          check_field("probing", int'(probing), int'(want.probing));
          check_field("is_own", int'(is_own), int'(want.is_own));
          check_field("node_dropped", int'(node_dropped), int'(want.node_dropped));
          check_field("sleep_request", int'(sleep_request), int'(want.sleep_request));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!quiet && out_calm == 0 && $urandom_range(0, 3) == 0) begin
        out_gap = $urandom_range(1, 8) - 1;
        if ($urandom_range(0, 2) == 0) out_calm = $urandom_range(20, 100);
        out_stall <= 1'b1;
      end else begin
        if (out_calm > 0) out_calm--;
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: idle-state ops, out-of-range ops, map edges, probe and own grant
    add_op(3'(OP_SET_NODE + 1), 1'b1, 7'd127, 1'b1);
    add_op(3'(OP_SET_NODE + 3), 1'b0, 7'd0, 1'b0);
    add_op(OP_ANSWER, 1'b0, 7'd0, 1'b0);
    add_op(OP_ANS_TIMEOUT, 1'b0, 7'd0, 1'b0);
    add_op(OP_SEND_TIMEOUT, 1'b1, 7'd0, 1'b0);
    add_op(OP_SET_NODE, 1'b0, 7'd0, 1'b1);
    add_op(OP_SET_NODE, 1'b1, 7'd127, 1'b1);
    add_op(OP_SET_NODE, 1'b0, 7'd2, 1'b1);
    add_op(OP_SET_NODE, 1'b0, 7'd0, 1'b0);
    add_op(OP_GRANT, 1'b0, 7'd0, 1'b0);
    add_op(OP_ANSWER, 1'b1, 7'd0, 1'b0);
    add_op(OP_GRANT, 1'b0, 7'd0, 1'b0);
    add_op(OP_SEND_TIMEOUT, 1'b0, 7'd0, 1'b0);
    add_op(OP_ANS_TIMEOUT, 1'b0, 7'd0, 1'b0);
    add_op(OP_SET_NODE, 1'b0, 7'd1, 1'b1);
    add_op(OP_GRANT, 1'b0, 7'd0, 1'b0);
    add_op(OP_GRANT, 1'b0, 7'd0, 1'b0);
    add_op(OP_SEND_TIMEOUT, 1'b0, 7'd0, 1'b0);
    add_op(OP_ANS_TIMEOUT, 1'b0, 7'd0, 1'b0);
    add_op(OP_SEND_TIMEOUT, 1'b0, 7'd0, 1'b0);
    add_op(OP_SEND_TIMEOUT, 1'b0, 7'd0, 1'b0);
    add_op(OP_GRANT, 1'b0, 7'd0, 1'b0);
    add_op(OP_ANSWER, 1'b0, 7'd0, 1'b0);
    add_op(3'(OP_SET_NODE + 2), 1'b1, 7'h55, 1'b1);
    add_op(OP_SET_NODE, 1'b1, 7'h2a, 1'b0);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_OWN_ADDRESS, 8'd127);
          write_reg(REG_MAX_FAILS, 8'd1);
          write_reg(REG_SLEEP_LAPS, 8'd0);
        end
        1: begin
          write_reg(REG_OWN_ADDRESS, 8'd0);
          write_reg(REG_MAX_FAILS, 8'd255);
          write_reg(REG_SLEEP_LAPS, 8'd255);
        end
        2: begin
          write_reg(REG_OWN_ADDRESS, 8'd1);
          write_reg(REG_MAX_FAILS, 8'd2);
          write_reg(REG_SLEEP_LAPS, 8'd1);
        end
        3: begin
          write_reg(REG_OWN_ADDRESS, 8'($urandom_range(0, 127)));
          write_reg(REG_MAX_FAILS, 8'($urandom_range(1, 8)));
          write_reg(REG_SLEEP_LAPS, 8'($urandom_range(0, 3)));
        end
        4: begin
          write_reg(REG_OWN_ADDRESS, 8'($urandom_range(0, 127)));
          write_reg(REG_MAX_FAILS, MAX_FAILS_RST);
          write_reg(REG_SLEEP_LAPS, SLEEP_LAPS_RST);
        end
        default: begin
          write_reg(REG_OWN_ADDRESS, 8'($urandom_range(0, 127)));
          write_reg(REG_MAX_FAILS, 8'($urandom_range(1, 4)));
          write_reg(REG_SLEEP_LAPS, 8'($urandom_range(0, 2)));
          quiet = 1'b1;
        end
      endcase
      add_traffic(PHASE_OPS);
      wait_idle();
    end

    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/bts_pkg.sv
rtl/core/bts_map_mem.sv
rtl/core/bts_row_find.sv
rtl/core/bts_ctrl.sv
rtl/core/bus_token_scheduler_top.sv
test/tb_bus_token_scheduler_top.sv
